// ===== rtl/text_mode_console_writer_defines.svh =====
// Assertion macros of the console writer RTL, included by tmcw_engine.
// Needs signals named clock and reset in the module that uses them.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TMCW_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tmcw assertion failed");

`define TMCW_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tmcw assertion failed");

`else

`define TMCW_ASSERT(lbl, prop)

`define TMCW_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/tmcw_pkg.sv =====
// Shared constants, codes and helper functions of the console writer.
// Used by every module of the block; depends on nothing.
package tmcw_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int CODE_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int ENTRY_W    = CODE_W + COLOR_W;
   localparam int ADDR_W     = 11;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;

   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [CODE_W-1:0]  NULL_CODE    = 8'd0;
   localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CODE_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;
   localparam logic [ENTRY_W-1:0] RESET_CELL   = 16'h0720;

   function automatic logic [ENTRY_W-1:0] make_cell(input logic [CODE_W-1:0] code,
                                                   input logic [COLOR_W-1:0] color);
      return {color, code};
   endfunction

endpackage

// ===== rtl/tmcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses the widths of tmcw_pkg for its defaults.
module tmcw_ram import tmcw_pkg::*; #(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = DEFAULT_ROWS * DEFAULT_COLUMNS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_address,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_address,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/tmcw_engine.sv =====
// Console sequencer: cursor, put and read handling, scroll copy, row fill,
// clearing pass and result register. Drives the cell RAM; uses tmcw_pkg.
`include "text_mode_console_writer_defines.svh"

module tmcw_engine import tmcw_pkg::*; #(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS,
   localparam int CELL_COUNT = ROWS * COLUMNS,
   localparam int CELL_W     = $clog2(CELL_COUNT),
   localparam int ROW_W      = $clog2(ROWS),
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [CODE_W-1:0]     req_char_code,
   input  logic [ADDR_W-1:0]     req_cell_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ENTRY_W-1:0]    rsp_cell_entry,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [COL_PORT_W-1:0] rsp_cursor_column,
   input  logic [COLOR_W-1:0]    color,
   output logic                  mem_we,
   output logic [CELL_W-1:0]     mem_waddr,
   output logic [ENTRY_W-1:0]    mem_wdata,
   output logic [CELL_W-1:0]     mem_raddr,
   input  logic [ENTRY_W-1:0]    mem_rdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL_READ,
      ST_SCROLL_LAST,
      ST_FILL,
      ST_DONE
   } state_type;

   localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELL_COUNT - 1);
   localparam logic [CELL_W-1:0] ROW_STRIDE = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] BOTTOM_ROW = CELL_W'(CELL_COUNT - COLUMNS);

   state_type            state_ff, state_in;
   logic [CELL_W-1:0]    sweep_ff, sweep_in;
   logic [CELL_W-1:0]    dst_ff, dst_in;
   logic                 copy_valid_ff, copy_valid_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ENTRY_W-1:0]   entry_ff, entry_in;
   logic                 in_range_ff, in_range_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]   rsp_entry_ff, rsp_entry_in;
   logic [ROW_PORT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_PORT_W-1:0] rsp_col_ff, rsp_col_in;

   logic [CELL_W-1:0]    put_index;
   logic [ENTRY_W-1:0]   put_cell;
   logic                 col_wrap;
   logic                 row_last;
   logic                 new_line;

   assign put_index = CELL_W'(row_ff) * ROW_STRIDE + CELL_W'(col_ff);
   assign put_cell  = make_cell(req_char_code, color);
   assign col_wrap  = (int'(col_ff) + 1) >= COLUMNS;
   assign row_last  = (int'(row_ff) + 1) >= ROWS;
   assign new_line  = (req_char_code == NEWLINE_CODE) || col_wrap;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      dst_in        = dst_ff;
      copy_valid_in = copy_valid_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      entry_in      = entry_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_entry_in  = rsp_entry_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = RESET_CELL;
      mem_raddr     = sweep_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            mem_raddr = CELL_W'(req_cell_address);
            if (req_valid) begin
               if (req_kind == KIND_READ) begin
                  in_range_in = int'(req_cell_address) < CELL_COUNT;
                  state_in    = ST_READ;
               end else if (req_char_code == NULL_CODE) begin
                  entry_in = '0;
                  state_in = ST_DONE;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = put_index;
                  mem_wdata = put_cell;
                  entry_in  = put_cell;
                  if (new_line) begin
                     col_in = '0;
                     if (row_last) begin
                        sweep_in      = ROW_STRIDE;
                        copy_valid_in = 1'b0;
                        state_in      = ST_SCROLL_READ;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        state_in = ST_DONE;
                     end
                  end else begin
                     col_in   = col_ff + 1'b1;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_READ: begin
            entry_in = in_range_ff ? mem_rdata : '0;
            state_in = ST_DONE;
         end
         ST_SCROLL_READ: begin
            mem_we        = copy_valid_ff;
            mem_waddr     = dst_ff;
            mem_wdata     = mem_rdata;
            dst_in        = sweep_ff - ROW_STRIDE;
            copy_valid_in = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_SCROLL_LAST;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_SCROLL_LAST: begin
            mem_we        = 1'b1;
            mem_waddr     = dst_ff;
            mem_wdata     = mem_rdata;
            copy_valid_in = 1'b0;
            sweep_in      = BOTTOM_ROW;
            state_in      = ST_FILL;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = make_cell(SPACE_CODE, color);
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = entry_ff;
               rsp_row_in   = ROW_PORT_W'(row_ff);
               rsp_col_in   = COL_PORT_W'(col_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         copy_valid_ff <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         copy_valid_ff <= copy_valid_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dst_ff       <= dst_in;
      entry_ff     <= entry_in;
      in_range_ff  <= in_range_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_entry    = rsp_entry_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;

   // The cursor never leaves the screen, and no write lands past the last cell.
   `TMCW_ASSERT(a_row_in_bounds, (int'(row_ff) < ROWS))
   `TMCW_ASSERT(a_col_in_bounds, (int'(col_ff) < COLUMNS))
   `TMCW_ASSERT(a_write_in_range, mem_we |-> (int'(mem_waddr) < CELL_COUNT))
   // An accepted transfer always takes the sequencer out of ST_IDLE in the next cycle.
   `TMCW_ASSERT(a_accept_busy, (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
   // The final copy write always follows the last copy read.
   `TMCW_ASSERT(a_scroll_order, (state_ff == ST_SCROLL_LAST) |-> $past(state_ff == ST_SCROLL_READ))

endmodule

// ===== rtl/text_mode_console_writer.sv =====
// Text-mode console writer: a character cell store with a cursor and scrolling.
// The request channel (req_) takes put-character and read-cell transfers; each
// one yields exactly one transfer on the response channel (rsp_), in order.
// A put stores the character with the current color at the cursor and reports
// the written entry and the new cursor; code 0 is dropped and reports entry 0.
// A read reports the stored cell at req_cell_address, or 0 past the last cell.
// csr_write_enable loads csr_write_data as the current color on that edge.
// The sequencer handles one transfer at a time. A put without scroll goes from idle
// to the done state, a read through the read state first; the done state loads the
// response register. A put that passes the bottom row scrolls through the single
// cell RAM port pair, one cell per cycle, then fills the bottom row with blanks.
// The next request is taken in the cycle after the response is registered,
// even while that response is still stalled; a second finished result then
// waits in the sequencer until the response register frees.
// After reset a clearing pass writes blanks to all ROWS*COLUMNS cells with req_stall
// high; the color register takes writes.
module text_mode_console_writer import tmcw_pkg::*; #(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [CODE_W-1:0]     req_char_code,
   input  logic [ADDR_W-1:0]     req_cell_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ENTRY_W-1:0]    rsp_cell_entry,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [COL_PORT_W-1:0] rsp_cursor_column,
   input  logic                  csr_write_enable,
   input  logic [COLOR_W-1:0]    csr_write_data
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int CELL_W     = $clog2(CELL_COUNT);

   logic [COLOR_W-1:0] color_ff, color_in;
   logic               mem_we;
   logic [CELL_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [CELL_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   assign color_in = csr_write_enable ? csr_write_data : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= RESET_COLOR;
      end else begin
         color_ff <= color_in;
      end
   end

   tmcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_char_code     (req_char_code),
      .req_cell_address  (req_cell_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_entry    (rsp_cell_entry),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .color             (color_ff),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata)
   );

   tmcw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock         (clock),
      .write_enable  (mem_we),
      .write_address (mem_waddr),
      .write_data    (mem_wdata),
      .read_address  (mem_raddr),
      .read_data     (mem_rdata)
   );

endmodule

// ===== tb/tb_text_mode_console_writer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_console_writer: directed rows, then phases of
// random text lines and cell reads under random stalls, checked against a screen mirror.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
module tb_text_mode_console_writer;
   import tmcw_pkg::*;

   localparam int COLUMNS        = DEFAULT_COLUMNS;
   localparam int ROWS           = DEFAULT_ROWS;
   localparam int CELL_COUNT     = COLUMNS * ROWS;
   localparam int ADDR_TOP       = (1 << ADDR_W) - 1;
   localparam int SETTLE_CYCLES  = CELL_COUNT + 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_TARGET    = 1950;
   localparam int PHASES         = 6;
   localparam int MAX_GAP        = 13;
   localparam int HOLD_OFF_AT    = 400;
   localparam int HOLD_OFF_LEN   = 600;
   localparam int PRINT_CAP      = 100;

   typedef struct packed {
      logic [ENTRY_W-1:0]    entry;
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] column;
   } cell_report_type;

   typedef enum logic [1:0] {STEP_PUT, STEP_READ, STEP_COLOR} step_kind_type;

   typedef struct {
      step_kind_type      action;
      logic [CODE_W-1:0]  value;
      logic [ADDR_W-1:0]  addr;
      bit                 typed;
      cell_report_type    want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [CODE_W-1:0]     req_char_code;
   logic [ADDR_W-1:0]     req_cell_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ENTRY_W-1:0]    rsp_cell_entry;
   logic [ROW_PORT_W-1:0] rsp_cursor_row;
   logic [COL_PORT_W-1:0] rsp_cursor_column;
   logic                  csr_write_enable;
   logic [COLOR_W-1:0]    csr_write_data;

   logic [ENTRY_W-1:0] mirror_cells [CELL_COUNT];
   int                 mirror_row;
   int                 mirror_col;
   logic [COLOR_W-1:0] mirror_color;

   cell_report_type expected_cell_reports [$];
   script_row_type  script [$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           sender_steady = 1'b0;
   bit           receiver_steady = 1'b0;

   always #10 clock = ~clock;

   text_mode_console_writer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_char_code     (req_char_code),
      .req_cell_address  (req_cell_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_entry    (rsp_cell_entry),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   function automatic cell_report_type mirror_item(input logic kind,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic [ADDR_W-1:0] addr);
      cell_report_type rep;
      int idx;
      rep.entry = '0;
      if (kind == KIND_READ) begin
         if (addr < CELL_COUNT) rep.entry = mirror_cells[addr];
      end else if (code != NULL_CODE) begin
         rep.entry = {mirror_color, code};
         mirror_cells[mirror_row * COLUMNS + mirror_col] = rep.entry;
         mirror_col++;
         if (code == NEWLINE_CODE || mirror_col >= COLUMNS) begin
            mirror_col = 0;
            if (mirror_row + 1 >= ROWS) begin
               for (idx = 0; idx < CELL_COUNT - COLUMNS; idx++)
                  mirror_cells[idx] = mirror_cells[idx + COLUMNS];
               for (idx = CELL_COUNT - COLUMNS; idx < CELL_COUNT; idx++)
                  mirror_cells[idx] = {mirror_color, SPACE_CODE};
            end else begin
               mirror_row++;
            end
         end
      end
      rep.row    = ROW_PORT_W'(mirror_row);
      rep.column = COL_PORT_W'(mirror_col);
      return rep;
   endfunction

   function automatic void add_step(input step_kind_type action, input logic [CODE_W-1:0] value,
                                    input logic [ADDR_W-1:0] addr, input bit typed = 1'b0,
                                    input logic [ENTRY_W-1:0] entry = '0, input int row = 0,
                                    input int column = 0);
      script_row_type r;
      r.action      = action;
      r.value       = value;
      r.addr        = addr;
      r.typed       = typed;
      r.want.entry  = entry;
      r.want.row    = ROW_PORT_W'(row);
      r.want.column = COL_PORT_W'(column);
      script.push_back(r);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic send_item(input logic kind, input logic [CODE_W-1:0] code,
                            input logic [ADDR_W-1:0] addr, input bit typed,
                            input cell_report_type typed_report);
      int gap;
      cell_report_type predicted;
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_char_code    <= code;
      req_cell_address <= addr;
      do @(posedge clock); while (req_stall);
      predicted = mirror_item(kind, code, addr);
      expected_cell_reports.push_back(typed ? typed_report : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_cell_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_color(input logic [COLOR_W-1:0] color);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror_color = color;
   endtask

   initial begin : stimulus
      int idx;
      int phase;
      int n;
      int per_phase;
      int pick;
      int line_left;
      logic [CODE_W-1:0] code;
      logic [ADDR_W-1:0] addr;
      req_valid        = 1'b0;
      req_kind         = KIND_PUT;
      req_char_code    = '0;
      req_cell_address = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      reset            = 1'b1;
      for (idx = 0; idx < CELL_COUNT; idx++) mirror_cells[idx] = RESET_CELL;
      mirror_row   = 0;
      mirror_col   = 0;
      mirror_color = RESET_COLOR;

      add_step(STEP_READ, '0, 11'd0, 1'b1, RESET_CELL, 0, 0);
      add_step(STEP_READ, '0, 11'(CELL_COUNT - 1), 1'b1, RESET_CELL, 0, 0);
      add_step(STEP_READ, '0, 11'(CELL_COUNT), 1'b1, '0, 0, 0);
      add_step(STEP_READ, '0, 11'(ADDR_TOP), 1'b1, '0, 0, 0);
      add_step(STEP_PUT, NULL_CODE, '0, 1'b1, '0, 0, 0);
      add_step(STEP_PUT, 8'h41, '0, 1'b1, {RESET_COLOR, 8'h41}, 0, 1);
      add_step(STEP_PUT, 8'hFF, '0, 1'b1, {RESET_COLOR, 8'hFF}, 0, 2);
      add_step(STEP_PUT, 8'h01, '0, 1'b1, {RESET_COLOR, 8'h01}, 0, 3);
      add_step(STEP_COLOR, 8'hFF, '0);
      add_step(STEP_PUT, NEWLINE_CODE, '0, 1'b1, {8'hFF, NEWLINE_CODE}, 1, 0);
      add_step(STEP_READ, '0, 11'd2);
      add_step(STEP_READ, '0, 11'd3);
      add_step(STEP_COLOR, 8'h00, '0);
      add_step(STEP_PUT, SPACE_CODE, '0, 1'b1, {8'h00, SPACE_CODE}, 1, 1);
      add_step(STEP_PUT, 8'h80, '0);
      add_step(STEP_PUT, 8'h7F, '0);
      add_step(STEP_READ, '0, 11'd80);
      add_step(STEP_READ, '0, 11'd81);
      add_step(STEP_PUT, NULL_CODE, '0);
      add_step(STEP_COLOR, 8'hA5, '0);
      add_step(STEP_PUT, 8'h5A, '0);
      add_step(STEP_PUT, NEWLINE_CODE, '0);
      add_step(STEP_READ, '0, 11'd1024);
      add_step(STEP_READ, '0, 11'd1023);
      add_step(STEP_PUT, 8'h0F, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         case (script[k].action)
            STEP_COLOR: set_color(script[k].value);
            STEP_PUT: send_item(KIND_PUT, script[k].value, script[k].addr, script[k].typed,
                                script[k].want);
            default: send_item(KIND_READ, script[k].value, script[k].addr, script[k].typed,
                               script[k].want);
         endcase
      end

      // Random part: lines of text of random length, mixed with cell reads and null codes.
      per_phase = (ITEM_TARGET - script.size()) / PHASES;
      line_left = $urandom_range(0, 120);
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) set_color(8'hFF);
         else if (phase == 1) set_color(8'h00);
         else set_color(8'($urandom_range(0, 255)));
         for (n = 0; n < per_phase; n++) begin
            if (phase == 2 && n == per_phase / 2) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               if (pick < 3) addr = 11'($urandom_range(CELL_COUNT, ADDR_TOP));
               else addr = 11'($urandom_range(0, CELL_COUNT - 1));
               send_item(KIND_READ, 8'($urandom), addr, 1'b0, '0);
            end else if (pick < 28) begin
               send_item(KIND_PUT, NULL_CODE, 11'($urandom), 1'b0, '0);
            end else begin
               if (line_left == 0) begin
                  code = NEWLINE_CODE;
                  line_left = $urandom_range(0, 120);
               end else begin
                  code = 8'($urandom_range(1, 255));
                  line_left--;
               end
               send_item(KIND_PUT, code, 11'($urandom), 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("text_mode_console_writer: match");
      end else begin
         $display("text_mode_console_writer: mismatch");
      end
      $finish;
   end

   initial begin : receiver
      int gap;
      int accepted;
      accepted  = 0;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
         if (accepted == HOLD_OFF_AT) gap = HOLD_OFF_LEN;
         else gap = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
         accepted++;
      end
   end

   always @(posedge clock) begin : response_check
      cell_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cell_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer: entry %h row %0d column %0d",
                                      rsp_cell_entry, rsp_cursor_row, rsp_cursor_column));
         end else begin
            want = expected_cell_reports.pop_front();
            if (rsp_cell_entry !== want.entry)
               report_mismatch($sformatf("cell entry %h, expected %h",
                                         rsp_cell_entry, want.entry));
            if (rsp_cursor_row !== want.row)
               report_mismatch($sformatf("cursor row %0d, expected %0d",
                                         rsp_cursor_row, want.row));
            if (rsp_cursor_column !== want.column)
               report_mismatch($sformatf("cursor column %0d, expected %0d",
                                         rsp_cursor_column, want.column));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("text_mode_console_writer: mismatch");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/tmcw_ram.sv
rtl/tmcw_engine.sv
rtl/text_mode_console_writer.sv
tb/tb_text_mode_console_writer.sv
